[sv/snc_pkg.sv]
// Package for the sparse neighbor cell counter.
// Holds the shared constants, the register indexes, the stage control struct
// and the sparse test function. It depends on nothing else.
package snc_pkg;

  localparam int CFG_W   = 9;
  localparam int INDEX_W = 2;
  localparam int COUNT_W = 17;

  localparam logic [7:0]         SET_CHAR     = 8'h40;
  localparam logic [3:0]         SPARSE_LIMIT = 4'd4;
  localparam logic [COUNT_W-1:0] TOTAL_MAX    = {COUNT_W{1'b1}};

  localparam logic [INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // Window bit index is row * 3 + col, with row 0 the oldest row and col 0
  // the oldest column. Each mask selects the in-window neighbors of a center.
  localparam logic [3:0] CTR_MID       = 4'd4;
  localparam logic [3:0] CTR_RIGHT     = 4'd5;
  localparam logic [3:0] CTR_LOW       = 4'd7;
  localparam logic [3:0] CTR_LOW_RIGHT = 4'd8;

  localparam logic [8:0] MASK_MID       = 9'b111_101_111;
  localparam logic [8:0] MASK_RIGHT     = 9'b110_010_110;
  localparam logic [8:0] MASK_LOW       = 9'b101_111_000;
  localparam logic [8:0] MASK_LOW_RIGHT = 9'b010_110_000;

  typedef struct packed {
    logic set;
    logic col_zero;
    logic row_ge1;
    logic row_ge2;
    logic last_col;
    logic last_row;
    logic frame_start;
  } cell_info_t;

  function automatic logic sparse(input logic [8:0] w, input logic [8:0] mask,
                                  input logic [3:0] center);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + {3'd0, w[i] & mask[i]};
    end
    return w[center] && (cnt < SPARSE_LIMIT);
  endfunction

endpackage

[sv/sparse_neighbor_cell_counter.sv]
// Top level of the sparse neighbor cell counter: handshake control around the
// front stage, the line buffers and the window stage.
// Depends on snc_pkg, snc_front, snc_line_buf and snc_back.
//
//   channel   direction  handshake                   word
//   cell      in         cell_valid / cell_ready     cell_byte
//   result    out        result_valid / result_ready sparse_count, frame_done
//   cfg       in         cfg_we (no ready)           cfg_index, cfg_data
//
// One cell word is taken per cycle while cell_ready is high. A taken cell sits in
// the input register while its line buffer bits are read, and its result enters
// the output register once that register is free or being read out.
// Reset leaves both sizes at 256 (or the maximum if less).
// A stalled result holds in the output register while one more cell waits in
// the input register; the cell channel stalls only when both are full.
module sparse_neighbor_cell_counter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [snc_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [snc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                cell_valid,
  output logic                                cell_ready,
  input  logic [7:0]                          cell_byte,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [snc_pkg::COUNT_W-1:0]         sparse_count,
  output logic                                frame_done
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                s1_valid;
  logic                s1_adv;
  logic                take;
  logic [CW-1:0]       rd_addr;
  logic [CW-1:0]       s1_col;
  logic [1:0]          rd_data;
  logic [1:0]          wr_data;
  snc_pkg::cell_info_t info;

  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign cell_ready = !s1_valid || s1_adv;
  assign take       = cell_valid && cell_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  snc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .cell_byte (cell_byte),
    .rd_addr   (rd_addr),
    .info      (info),
    .s1_col    (s1_col)
  );

  snc_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (s1_adv),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  snc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (s1_adv),
    .info         (info),
    .rd_data      (rd_data),
    .wr_data      (wr_data),
    .sparse_count (sparse_count),
    .frame_done   (frame_done)
  );

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("a waiting cell word was dropped");
`endif

endmodule

[sv/snc_line_buf.sv]
// Two one-bit line buffers (row r-2 and row r-1) kept as one two-bit memory.
// Read data is registered; a write to the address being read is forwarded.
// Uses no package.
module snc_line_buf #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (we && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

[sv/snc_front.sv]
// Front stage: grid size registers, raster position counters and the input
// register that feeds the window stage. Depends on snc_pkg.
module snc_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CW         = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [snc_pkg::INDEX_W-1:0]             cfg_index,
  input  logic [snc_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                    take,
  input  logic [7:0]                              cell_byte,
  output logic [CW-1:0]                           rd_addr,
  output snc_pkg::cell_info_t                     info,
  output logic [CW-1:0]                           s1_col
);

  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int WIDTH_RST  = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
  localparam int HEIGHT_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

  logic [WW-1:0] grid_width;
  logic [HW-1:0] grid_height;
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic [31:0] cfg_ext;
  logic [31:0] width_sel;
  logic [31:0] height_sel;
  logic        last_col;
  logic        last_row;
  snc_pkg::cell_info_t info_next;

  always_comb begin
    cfg_ext = 32'(cfg_data);
    if (cfg_ext == 32'd0) begin
      width_sel  = 32'd1;
      height_sel = 32'd1;
    end else begin
      width_sel  = (cfg_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : cfg_ext;
      height_sel = (cfg_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= WW'(WIDTH_RST);
      grid_height <= HW'(HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        snc_pkg::REG_GRID_WIDTH: begin
          grid_width <= WW'(width_sel);
        end
        snc_pkg::REG_GRID_HEIGHT: begin
          grid_height <= HW'(height_sel);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    last_col = (32'(col) + 32'd1) >= 32'(grid_width);
    last_row = (32'(row) + 32'd1) >= 32'(grid_height);
    info_next.set         = (cell_byte == snc_pkg::SET_CHAR);
    info_next.col_zero    = (col == '0);
    info_next.row_ge1     = (row != '0);
    info_next.row_ge2     = (32'(row) >= 32'd2);
    info_next.last_col    = last_col;
    info_next.last_row    = last_row;
    info_next.frame_start = (col == '0) && (row == '0);
  end

  assign rd_addr = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_we) begin
      if ((cfg_index == snc_pkg::REG_GRID_WIDTH) ||
          (cfg_index == snc_pkg::REG_GRID_HEIGHT)) begin
        col <= '0;
        row <= '0;
      end
    end else if (take) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      info   <= info_next;
      s1_col <= col;
    end
  end

`ifndef ASSERT_OFF
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    32'(col) < 32'(grid_width))
    else $error("column position is outside the frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    32'(row) < 32'(grid_height))
    else $error("row position is outside the frame height");
`endif

endmodule

[sv/snc_back.sv]
// Window stage: shifts the 3x3 window, decides the cells that are complete,
// keeps the saturating running count and holds the result register.
// Depends on snc_pkg.
module snc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  snc_pkg::cell_info_t                 info,
  input  logic [1:0]                          rd_data,
  output logic [1:0]                          wr_data,
  output logic [snc_pkg::COUNT_W-1:0]         sparse_count,
  output logic                                frame_done
);

  logic [8:0] window;
  logic [8:0] w_base;
  logic [8:0] window_next;
  logic       o_bit;
  logic       p_bit;
  logic [2:0] add;
  logic [snc_pkg::COUNT_W-1:0] base;
  logic [snc_pkg::COUNT_W:0]   sum;
  logic [snc_pkg::COUNT_W-1:0] sparse_count_next;

  always_comb begin
    o_bit  = info.row_ge2 & rd_data[1];
    p_bit  = info.row_ge1 & rd_data[0];
    w_base = info.col_zero ? 9'd0 : window;
    window_next = {info.set, w_base[8:7], p_bit, w_base[5:4], o_bit, w_base[2:1]};

    add = {2'd0, info.row_ge1 & ~info.col_zero &
                 snc_pkg::sparse(window_next, snc_pkg::MASK_MID, snc_pkg::CTR_MID)}
        + {2'd0, info.row_ge1 & info.last_col &
                 snc_pkg::sparse(window_next, snc_pkg::MASK_RIGHT, snc_pkg::CTR_RIGHT)}
        + {2'd0, info.last_row & ~info.col_zero &
                 snc_pkg::sparse(window_next, snc_pkg::MASK_LOW, snc_pkg::CTR_LOW)}
        + {2'd0, info.last_row & info.last_col &
                 snc_pkg::sparse(window_next, snc_pkg::MASK_LOW_RIGHT,
                                 snc_pkg::CTR_LOW_RIGHT)};

    base = info.frame_start ? '0 : sparse_count;
    sum  = {1'b0, base} + (snc_pkg::COUNT_W + 1)'(add);
    sparse_count_next = sum[snc_pkg::COUNT_W] ? snc_pkg::TOTAL_MAX
                                              : sum[snc_pkg::COUNT_W-1:0];
  end

  // The older row takes the previous row's bit, the previous row the new one.
  assign wr_data = {rd_data[0], info.set};

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      sparse_count <= '0;
      frame_done   <= 1'b0;
    end else if (adv) begin
      window       <= window_next;
      sparse_count <= sparse_count_next;
      frame_done   <= info.last_col & info.last_row;
    end
  end

`ifndef ASSERT_OFF
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (adv && !info.frame_start) |=> (sparse_count >= $past(sparse_count)))
    else $error("running count fell inside a frame");
`endif

endmodule

[dv/sparse_neighbor_cell_counter_tb.sv]
// Testbench for the sparse neighbor cell counter: a directed table, then random grids.
// Results are checked against a cycle-free predictor kept inside this module.
// Depends on snc_pkg and sparse_neighbor_cell_counter.
module sparse_neighbor_cell_counter_tb;

  localparam int                 GRID_MAX    = 256;
  localparam int                 ITEM_TARGET = 1450;
  localparam int                 PHASE_CAP   = 520;
  localparam int                 HOLD_CYCLES = 100;
  localparam int                 SETTLE      = 4;
  localparam int                 TIMEOUT     = 2_000_000;
  localparam logic [7:0]         DOT_CHAR    = 8'h2E;
  localparam logic [snc_pkg::INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [snc_pkg::INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {STEP_CELL, STEP_REG} step_kind_t;

  typedef struct packed {
    logic [snc_pkg::COUNT_W-1:0] count;
    logic                        done;
  } tally_t;

  typedef struct packed {
    step_kind_t                  kind;
    logic [snc_pkg::INDEX_W-1:0] index;
    logic [snc_pkg::CFG_W-1:0]   value;
    logic [7:0]                  data;
    logic                        fixed;
    tally_t                      want;
  } step_t;

  localparam int SCRIPT_LEN = 33;

  step_t script [SCRIPT_LEN] = '{
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b1, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   8'hFF,             1'b1, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   8'h00,             1'b1, '{17'd0, 1'b0}},
    '{STEP_REG,  snc_pkg::REG_GRID_WIDTH,  9'd0,   8'h00,             1'b0, '{17'd0, 1'b0}},
    '{STEP_REG,  snc_pkg::REG_GRID_HEIGHT, 9'd0,   8'h00,             1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b1, '{17'd1, 1'b1}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   8'hC0,             1'b1, '{17'd0, 1'b1}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b1, '{17'd1, 1'b1}},
    '{STEP_REG,  snc_pkg::REG_GRID_WIDTH,  9'd3,   8'h00,             1'b0, '{17'd0, 1'b0}},
    '{STEP_REG,  snc_pkg::REG_GRID_HEIGHT, 9'd3,   8'h00,             1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b1, '{17'd4, 1'b1}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   DOT_CHAR,          1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_REG,  REG_SPARE_A,              9'h1FF, 8'h00,             1'b0, '{17'd0, 1'b0}},
    '{STEP_REG,  REG_SPARE_B,              9'd0,   8'h00,             1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   DOT_CHAR,          1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   DOT_CHAR,          1'b0, '{17'd0, 1'b0}},
    '{STEP_REG,  snc_pkg::REG_GRID_WIDTH,  9'h1FF, 8'h00,             1'b0, '{17'd0, 1'b0}},
    '{STEP_REG,  snc_pkg::REG_GRID_HEIGHT, 9'd257, 8'h00,             1'b0, '{17'd0, 1'b0}},
    '{STEP_CELL, snc_pkg::REG_GRID_WIDTH,  9'd0,   snc_pkg::SET_CHAR, 1'b1, '{17'd0, 1'b0}}
  };

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [snc_pkg::INDEX_W-1:0] cfg_index;
  logic [snc_pkg::CFG_W-1:0]   cfg_data;
  logic                        cell_valid;
  logic                        cell_ready;
  logic [7:0]                  cell_byte;
  logic                        result_valid;
  logic                        result_ready;
  logic [snc_pkg::COUNT_W-1:0] sparse_count;
  logic                        frame_done;

  bit          older_row [GRID_MAX];
  bit          upper_row [GRID_MAX];
  bit [8:0]    win_q;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned width_used;
  int unsigned height_used;
  int unsigned running;

  tally_t pending_tallies [$];
  int     errors     = 0;
  int     cells_sent = 0;
  int     burst_left = 0;
  bit     hold_req   = 1'b0;

  sparse_neighbor_cell_counter u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .cell_byte    (cell_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sparse_count (sparse_count),
    .frame_done   (frame_done)
  );

  function automatic bit win_at(bit [8:0] w, int r, int c);
    if (r < 0 || r > 2 || c < 0 || c > 2) return 1'b0;
    return w[r * 3 + c];
  endfunction

  function automatic bit is_lonely(bit [8:0] w, int r, int c);
    int cnt;
    cnt = 0;
    if (!win_at(w, r, c)) return 1'b0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) cnt += win_at(w, r + dr, c + dc);
      end
    end
    return cnt < snc_pkg::SPARSE_LIMIT;
  endfunction

  function automatic int unsigned clamp_size(logic [snc_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  function automatic void start_frame();
    win_q   = '0;
    col_pos = 0;
    row_pos = 0;
    running = 0;
  endfunction

  function automatic void apply_reg(logic [snc_pkg::INDEX_W-1:0] idx,
                                    logic [snc_pkg::CFG_W-1:0] v);
    case (idx)
      snc_pkg::REG_GRID_WIDTH: begin
        width_used = clamp_size(v);
        start_frame();
      end
      snc_pkg::REG_GRID_HEIGHT: begin
        height_used = clamp_size(v);
        start_frame();
      end
      default: begin
      end
    endcase
  endfunction

  // Cell (r-1, c-1) is decided when cell (r, c) arrives; the last column and
  // the last row are decided as soon as their cells are in the window.
  function automatic tally_t score_cell(logic [7:0] b);
    bit          x, o, p, lc, lr;
    bit [8:0]    w;
    int unsigned c, r;
    tally_t      t;
    c  = col_pos;
    r  = row_pos;
    x  = (b == snc_pkg::SET_CHAR);
    o  = (r >= 2) ? older_row[c] : 1'b0;
    p  = (r >= 1) ? upper_row[c] : 1'b0;
    lc = (c + 1 >= width_used);
    lr = (r + 1 >= height_used);
    if (c == 0 && r == 0) running = 0;
    older_row[c] = upper_row[c];
    upper_row[c] = x;
    w = (c == 0) ? 9'd0 : win_q;
    w = {x, w[8:7], p, w[5:4], o, w[2:1]};
    win_q = w;
    if (r >= 1 && c >= 1) running += is_lonely(w, 1, 1);
    if (r >= 1 && lc) running += is_lonely(w, 1, 2);
    if (lr && c >= 1) running += is_lonely(w, 2, 1);
    if (lr && lc) running += is_lonely(w, 2, 2);
    if (running > snc_pkg::TOTAL_MAX) running = snc_pkg::TOTAL_MAX;
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    t.count = running[snc_pkg::COUNT_W-1:0];
    t.done  = lc && lr;
    return t;
  endfunction

  function automatic logic [7:0] pick_byte(int unsigned dens);
    if ($urandom_range(0, 99) < dens) return snc_pkg::SET_CHAR;
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return DOT_CHAR;
  endfunction

  task automatic offer_cell(logic [7:0] b, bit fixed, tally_t want);
    tally_t t;
    if (burst_left == 0) begin
      cell_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 80);
    end
    burst_left--;
    cell_valid <= 1'b1;
    cell_byte  <= b;
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
    t = score_cell(b);
    pending_tallies.insert(pending_tallies.size(), fixed ? want : t);
    cells_sent++;
  endtask

  task automatic drain_results();
    cell_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [snc_pkg::INDEX_W-1:0] idx,
                           logic [snc_pkg::CFG_W-1:0] v);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, v);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : result_sink
    int mode;
    int left;
    int held;
    result_ready <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(5, 60);
        end
        left--;
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= ($urandom_range(0, 3) != 0);
          2: result_ready <= 1'($urandom_range(0, 1));
          default: result_ready <= ~result_ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    tally_t want_t;
    if (!rst && result_valid && result_ready) begin
      if (pending_tallies.size() == 0) begin
        errors++;
        $display("%0t: word with nothing expected, sparse_count %0d frame_done %0b",
                 $time, sparse_count, frame_done);
      end else begin
        want_t = pending_tallies.pop_front();
        if (sparse_count !== want_t.count) begin
          errors++;
          $display("%0t: sparse_count expected %0d, got %0d",
                   $time, want_t.count, sparse_count);
        end
        if (frame_done !== want_t.done) begin
          errors++;
          $display("%0t: frame_done expected %0b, got %0b",
                   $time, want_t.done, frame_done);
        end
      end
    end
  end

  initial begin : stimulus
    step_t                     s;
    int unsigned               area;
    int unsigned               n;
    int unsigned               dens;
    logic [snc_pkg::CFG_W-1:0] w_raw;
    logic [snc_pkg::CFG_W-1:0] h_raw;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    cell_valid <= 1'b0;
    cell_byte  <= '0;
    rst        <= 1'b1;
    width_used  = GRID_MAX;
    height_used = GRID_MAX;
    start_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      s = script[i];
      if (s.kind == STEP_REG) write_reg(s.index, s.value);
      else offer_cell(s.data, s.fixed, s.want);
    end

    // The sink holds off while cells keep coming, so the input stalls.
    write_reg(snc_pkg::REG_GRID_WIDTH, 9'd16);
    write_reg(snc_pkg::REG_GRID_HEIGHT, 9'd8);
    hold_req   = 1'b1;
    burst_left = 200;
    repeat (128) offer_cell(pick_byte(40), 1'b0, '0);

    while (cells_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          w_raw = 9'd1;
          h_raw = snc_pkg::CFG_W'($urandom_range(1, 40));
        end
        1: begin
          w_raw = snc_pkg::CFG_W'($urandom_range(1, GRID_MAX));
          h_raw = 9'd1;
        end
        2: begin
          w_raw = $urandom_range(0, 1) ? snc_pkg::CFG_W'($urandom_range(GRID_MAX + 1, 511))
                                       : snc_pkg::CFG_W'(GRID_MAX);
          h_raw = snc_pkg::CFG_W'($urandom_range(0, 2));
        end
        3: begin
          w_raw = snc_pkg::CFG_W'($urandom_range(0, 2));
          h_raw = $urandom_range(0, 1) ? snc_pkg::CFG_W'(GRID_MAX)
                                       : snc_pkg::CFG_W'($urandom_range(GRID_MAX + 1, 511));
        end
        default: begin
          w_raw = snc_pkg::CFG_W'($urandom_range(2, 12));
          h_raw = snc_pkg::CFG_W'($urandom_range(2, 12));
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(snc_pkg::REG_GRID_WIDTH, w_raw);
        if ($urandom_range(0, 5) != 0) write_reg(snc_pkg::REG_GRID_HEIGHT, h_raw);
      end else begin
        write_reg(snc_pkg::REG_GRID_HEIGHT, h_raw);
        if ($urandom_range(0, 5) != 0) write_reg(snc_pkg::REG_GRID_WIDTH, w_raw);
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  snc_pkg::CFG_W'($urandom));
      end
      area = width_used * height_used;
      n    = area * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0 && area > 1) n += $urandom_range(1, area - 1);
      if (n > PHASE_CAP) n = PHASE_CAP;
      if (n > ITEM_TARGET - cells_sent) n = ITEM_TARGET - cells_sent;
      dens = $urandom_range(0, 100);
      repeat (n) begin
        if ($urandom_range(0, 149) == 0) drain_results();
        offer_cell(pick_byte(dens), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE * 2) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/snc_pkg.sv
sv/snc_line_buf.sv
sv/snc_front.sv
sv/snc_back.sv
sv/sparse_neighbor_cell_counter.sv
dv/sparse_neighbor_cell_counter_tb.sv
